FILE: rtl/rsl_pkg.sv
// ----------------------------------------------------------------------------
// rsl_pkg
// Shared widths, fixed-point constants and register indexes for the radial
// spotlight luminance block.
// ----------------------------------------------------------------------------
package rsl_pkg;

  // configuration register width (signed center coordinates)
  localparam int unsigned CfgW = 14;

  // defaults for the top-level parameters
  localparam int unsigned CoordWidthDef = 12;
  localparam int unsigned LumWidthDef   = 16;

  // square root datapath
  localparam int unsigned RootW = 16;          // distance in Q8.8, below 160.0
  localparam int unsigned RadW  = 2 * RootW;   // radicand: clamped s, 16 zero bits
  localparam int unsigned RemW  = RootW + 3;   // partial remainder

  // saturation: d8 >= 160*256 exactly when s >= 160*160
  localparam int unsigned DistLimSq = 25600;

  // falloff factor, 16 fraction bits, 17 bits so that 1.0 fits
  localparam int unsigned FracW   = 16;
  localparam int unsigned FactorW = FracW + 1;
  localparam logic [FactorW-1:0] FracOne     = FactorW'(65536);
  localparam logic [FactorW-1:0] FactorFloor = FactorW'(13107);

  // d8*128/100 = (d8*32)/25, done as multiply by ceil(2^26/25) and shift
  localparam int unsigned ScaledW    = RootW + 5;
  localparam int unsigned RecipShift = 26;
  localparam int unsigned RecipW     = 22;
  localparam logic [RecipW-1:0] RecipMul = RecipW'((2 ** RecipShift + 24) / 25);

  typedef enum logic [0:0] {
    CfgCenterCol = 1'b0,
    CfgCenterRow = 1'b1
  } cfg_idx_e;

endpackage

FILE: rtl/rsl_front.sv
// ----------------------------------------------------------------------------
// rsl_front
// Offset from the center, squares and sum of squares; clamps the squared
// distance at the saturation point and forms the square root radicand.
// ----------------------------------------------------------------------------
module rsl_front
  import rsl_pkg::*;
#(
  parameter int unsigned CoordWidth = CoordWidthDef,
  parameter int unsigned LumWidth   = LumWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [CoordWidth-1:0] pixel_col_i,
  input  logic [CoordWidth-1:0] pixel_row_i,
  input  logic [LumWidth-1:0]   lum_i,
  input  logic [CfgW-1:0]       center_col_i,
  input  logic [CfgW-1:0]       center_row_i,
  output logic                  valid_o,
  output logic [RadW-1:0]       rad_o,
  output logic                  sat_o,
  output logic [LumWidth-1:0]   lum_o
);

  localparam int unsigned AbsW = ((CoordWidth > CfgW - 1) ? CoordWidth : CfgW - 1) + 1;
  localparam int unsigned DiffW = AbsW + 1;
  localparam int unsigned SqW   = 2 * AbsW;
  localparam int unsigned SumW  = SqW + 1;

  logic signed [DiffW-1:0] dx, dy;
  logic [AbsW-1:0]         adx_d, ady_d, adx_q, ady_q;
  logic [SqW-1:0]          sqx_q, sqy_q;
  logic [SumW-1:0]         sum;
  logic                    sat;
  logic [RootW-1:0]        clamped;
  logic [2:0]              valid_q;
  logic [LumWidth-1:0]     lum_a_q, lum_b_q;

  always_comb begin
    dx = $signed({{(DiffW-CoordWidth){1'b0}}, pixel_col_i})
       - $signed({{(DiffW-CfgW){center_col_i[CfgW-1]}}, center_col_i});
    dy = $signed({{(DiffW-CoordWidth){1'b0}}, pixel_row_i})
       - $signed({{(DiffW-CfgW){center_row_i[CfgW-1]}}, center_row_i});
    adx_d = dx[DiffW-1] ? AbsW'(-dx) : AbsW'(dx);
    ady_d = dy[DiffW-1] ? AbsW'(-dy) : AbsW'(dy);
  end

  always_comb begin
    sum     = SumW'(sqx_q) + SumW'(sqy_q);
    sat     = (sum >= SumW'(DistLimSq));
    clamped = sat ? RootW'(DistLimSq - 1) : sum[RootW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    adx_q   <= adx_d;
    ady_q   <= ady_d;
    lum_a_q <= lum_i;
    sqx_q   <= SqW'(adx_q) * SqW'(adx_q);
    sqy_q   <= SqW'(ady_q) * SqW'(ady_q);
    lum_b_q <= lum_a_q;
    rad_o   <= {clamped, {(RadW-RootW){1'b0}}};
    sat_o   <= sat;
    lum_o   <= lum_b_q;
  end

  assign valid_o = valid_q[2];

endmodule

FILE: rtl/rsl_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rsl_sqrt_cell
// One step of a restoring integer square root: takes the next two radicand
// bits, decides one root bit and passes everything on to the next cell.
// ----------------------------------------------------------------------------
module rsl_sqrt_cell
  import rsl_pkg::*;
#(
  parameter int unsigned LumWidth = LumWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [RadW-1:0]     rad_i,
  input  logic [RemW-1:0]     rem_i,
  input  logic [RootW-1:0]    root_i,
  input  logic                sat_i,
  input  logic [LumWidth-1:0] lum_i,
  output logic                valid_o,
  output logic [RadW-1:0]     rad_o,
  output logic [RemW-1:0]     rem_o,
  output logic [RootW-1:0]    root_o,
  output logic                sat_o,
  output logic [LumWidth-1:0] lum_o
);

  logic [RemW-1:0] cur, trial;
  logic            ge;

  always_comb begin
    cur   = {rem_i[RemW-3:0], rad_i[RadW-1 -: 2]};
    trial = RemW'({root_i, 2'b01});
    ge    = (cur >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_o  <= {rad_i[RadW-3:0], 2'b00};
    rem_o  <= ge ? cur - trial : cur;
    root_o <= {root_i[RootW-2:0], ge};
    sat_o  <= sat_i;
    lum_o  <= lum_i;
  end

endmodule

FILE: rtl/rsl_scale.sv
// ----------------------------------------------------------------------------
// rsl_scale
// Turns the Q8.8 distance into the falloff factor and applies it to the
// luminance with a truncated product.
// ----------------------------------------------------------------------------
module rsl_scale
  import rsl_pkg::*;
#(
  parameter int unsigned LumWidth = LumWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [RootW-1:0]    root_i,
  input  logic                sat_i,
  input  logic [LumWidth-1:0] lum_i,
  output logic                valid_o,
  output logic [LumWidth-1:0] lum_o
);

  localparam int unsigned RecProdW = ScaledW + RecipW;
  localparam int unsigned ProdW    = LumWidth + FactorW;

  logic [RecProdW-1:0] rec_prod;
  logic [RootW-1:0]    off_q;
  logic                sat_q;
  logic [LumWidth-1:0] lum_q;
  logic [FactorW-1:0]  factor;
  logic [ProdW-1:0]    prod;
  logic [1:0]          valid_q;

  // floor(d8*32/25) by reciprocal multiply, exact over the unsaturated range
  assign rec_prod = RecProdW'({root_i, 5'b0}) * RecProdW'(RecipMul);

  always_comb begin
    factor = sat_q ? FactorFloor : FracOne - FactorW'(off_q);
    prod   = ProdW'(lum_q) * ProdW'(factor);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= rec_prod[RecipShift +: RootW];
    sat_q <= sat_i;
    lum_q <= lum_i;
    lum_o <= prod[FracW +: LumWidth];
  end

  assign valid_o = valid_q[1];

endmodule

FILE: rtl/radial_spotlight_luminance.sv
// ----------------------------------------------------------------------------
// radial_spotlight_luminance
// Radial vignette: scales pixel luminance by a linear falloff with distance
// from a configurable center, saturating at 0.2 from 160 pixels outward.
// ----------------------------------------------------------------------------
// One pixel is taken in every clock cycle (busy_o stays low) and its result
// appears on lum_out_o with done_o high for one cycle, in input order. Each
// pixel passes through registers for the offset, the squares and the sum,
// then a chain of 16 square root cells that each decide one root bit, then
// registers for the factor and the final multiply. Results cannot
// be held off: the receiver must take each one in the cycle it is shown.
// Write the center registers only while no pixel is in flight.
module radial_spotlight_luminance
  import rsl_pkg::*;
#(
  parameter int unsigned CoordWidth = CoordWidthDef,
  parameter int unsigned LumWidth   = LumWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [CoordWidth-1:0] pixel_col_i,
  input  logic [CoordWidth-1:0] pixel_row_i,
  input  logic [LumWidth-1:0]   lum_in_i,
  output logic                  done_o,
  output logic [LumWidth-1:0]   lum_out_o,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_idx_i,
  input  logic [CfgW-1:0]       cfg_data_i
);

  logic [CfgW-1:0] center_col_q, center_row_q;

  logic [RootW:0]               valid_c;
  logic [RootW:0][RadW-1:0]     rad_c;
  logic [RootW:0][RemW-1:0]     rem_c;
  logic [RootW:0][RootW-1:0]    root_c;
  logic [RootW:0]               sat_c;
  logic [RootW:0][LumWidth-1:0] lum_c;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_col_q <= '0;
      center_row_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgCenterCol: center_col_q <= cfg_data_i;
        CfgCenterRow: center_row_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rsl_front #(
    .CoordWidth(CoordWidth),
    .LumWidth  (LumWidth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (start_i && !busy_o),
    .pixel_col_i (pixel_col_i),
    .pixel_row_i (pixel_row_i),
    .lum_i       (lum_in_i),
    .center_col_i(center_col_q),
    .center_row_i(center_row_q),
    .valid_o     (valid_c[0]),
    .rad_o       (rad_c[0]),
    .sat_o       (sat_c[0]),
    .lum_o       (lum_c[0])
  );

  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  // one root bit per cell, most significant first
  for (genvar i = 0; i < RootW; i++) begin : g_cell
    rsl_sqrt_cell #(
      .LumWidth(LumWidth)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_c[i]),
      .rad_i  (rad_c[i]),
      .rem_i  (rem_c[i]),
      .root_i (root_c[i]),
      .sat_i  (sat_c[i]),
      .lum_i  (lum_c[i]),
      .valid_o(valid_c[i+1]),
      .rad_o  (rad_c[i+1]),
      .rem_o  (rem_c[i+1]),
      .root_o (root_c[i+1]),
      .sat_o  (sat_c[i+1]),
      .lum_o  (lum_c[i+1])
    );
  end

  rsl_scale #(
    .LumWidth(LumWidth)
  ) u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_c[RootW]),
    .root_i (root_c[RootW]),
    .sat_i  (sat_c[RootW]),
    .lum_i  (lum_c[RootW]),
    .valid_o(done_o),
    .lum_o  (lum_out_o)
  );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the radial spotlight luminance block: pixels are
// sent as start/busy transfers, each scaled luminance on done_o is checked
// against an in-bench vignette predictor, over several spotlight centers.
// ----------------------------------------------------------------------------
module tb_top;
  import rsl_pkg::*;

  localparam int unsigned CoordW = 12;
  localparam int unsigned LumW   = 16;

  // fixed-point constants of the falloff
  localparam longint unsigned SatDistQ8 = 160 * 256;
  localparam longint unsigned OneQ16    = 65536;
  localparam longint unsigned FloorQ16  = 13107;

  localparam int NumPhases  = 8;
  localparam int SettleCyc  = 32;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic signed [CfgW-1:0] ccol;
    logic signed [CfgW-1:0] crow;
    logic [CoordW-1:0]      col;
    logic [CoordW-1:0]      row;
    logic [LumW-1:0]        lum;
    logic                   typed;
    logic [LumW-1:0]        lum_exp;
  } dir_row_t;

  typedef struct {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [LumW-1:0]   lum;
    logic [LumW-1:0]   lum_exp;
  } lum_expect_t;

  // directed pixels; typed results are read straight off the falloff law
  localparam int DirRows = 21;
  localparam dir_row_t DirTbl [DirRows] = '{
    '{14'sd0,     14'sd0,     12'd0,    12'd0,    16'hFFFF, 1'b1, 16'hFFFF},
    '{14'sd0,     14'sd0,     12'd0,    12'd0,    16'h0000, 1'b1, 16'h0000},
    '{14'sd0,     14'sd0,     12'd0,    12'd0,    16'h1234, 1'b1, 16'h1234},
    '{14'sd0,     14'sd0,     12'd1,    12'd0,    16'hFFFF, 1'b1, 16'd65208},
    '{14'sd0,     14'sd0,     12'd3,    12'd4,    16'h8000, 1'b1, 16'd31949},
    '{14'sd0,     14'sd0,     12'd159,  12'd0,    16'hFFFF, 1'b1, 16'd13434},
    '{14'sd0,     14'sd0,     12'd160,  12'd0,    16'hFFFF, 1'b1, 16'd13106},
    '{14'sd0,     14'sd0,     12'd0,    12'd160,  16'hFFFF, 1'b1, 16'd13106},
    '{14'sd0,     14'sd0,     12'd4095, 12'd4095, 16'hFFFF, 1'b1, 16'd13106},
    '{14'sd0,     14'sd0,     12'd4095, 12'd0,    16'h0001, 1'b1, 16'd0},
    '{14'sd0,     14'sd0,     12'd113,  12'd113,  16'hFFFF, 1'b0, 16'd0},
    '{14'sd0,     14'sd0,     12'hAAA,  12'h555,  16'h5555, 1'b0, 16'd0},
    '{14'sd0,     14'sd0,     12'h555,  12'hAAA,  16'hAAAA, 1'b0, 16'd0},
    '{14'sd100,   14'sd100,   12'd100,  12'd100,  16'hBEEF, 1'b1, 16'hBEEF},
    '{14'sd100,   14'sd100,   12'd0,    12'd0,    16'hFFFF, 1'b0, 16'd0},
    '{14'sd100,   14'sd100,   12'd213,  12'd28,   16'h7FFF, 1'b0, 16'd0},
    '{-14'sd8192, -14'sd8192, 12'd0,    12'd0,    16'hFFFF, 1'b1, 16'd13106},
    '{14'sd8191,  14'sd8191,  12'd4095, 12'd4095, 16'hFFFF, 1'b1, 16'd13106},
    '{-14'sd8192, 14'sd8191,  12'd4095, 12'd0,    16'h8000, 1'b1, 16'd6553},
    '{14'sd2048,  -14'sd1,    12'd2048, 12'd0,    16'hFFFF, 1'b1, 16'd65208},
    '{-14'sd1,    -14'sd1,    12'd0,    12'd0,    16'hFFFF, 1'b0, 16'd0}
  };

  // random phases: center, length and sender idle percentage
  localparam int PhaseCol [NumPhases] = '{0, -8192, 8191, 2048, -8192, 8191, 4095, -37};
  localparam int PhaseRow [NumPhases] = '{0, -8192, 8191, 2048, 8191, -8192, 0, 4100};
  localparam int PhaseLen [NumPhases] = '{300, 120, 120, 300, 120, 120, 300, 300};
  // receiver stalls do not apply here, so those phases run without sender gaps
  localparam int PhaseIdle [NumPhases] = '{0, 84, 0, 6, 0, 84, 0, 6};

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [CoordW-1:0] pixel_col_i;
  logic [CoordW-1:0] pixel_row_i;
  logic [LumW-1:0]   lum_in_i;
  logic              done_o;
  logic [LumW-1:0]   lum_out_o;
  logic              cfg_we_i;
  logic [0:0]        cfg_idx_i;
  logic [CfgW-1:0]   cfg_data_i;

  // typed expectation that travels with the pixel being offered
  logic              drv_typed;
  logic [LumW-1:0]   drv_typed_lum;

  // center as seen by the predictor, updated on sampled writes
  logic signed [CfgW-1:0] spot_col;
  logic signed [CfgW-1:0] spot_row;
  // center last written by the stimulus side
  int drv_ccol;
  int drv_crow;

  lum_expect_t lum_expect_q [$];

  int fail_cnt;
  int pixels_sent;
  int results_seen;
  int in_radius_cnt;
  int saturated_cnt;
  int center_writes;

  radial_spotlight_luminance #(
    .CoordWidth(CoordW),
    .LumWidth  (LumW)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .pixel_col_i(pixel_col_i),
    .pixel_row_i(pixel_row_i),
    .lum_in_i   (lum_in_i),
    .done_o     (done_o),
    .lum_out_o  (lum_out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // floor square root, bit by bit from the top
  function automatic longint unsigned floor_sqrt(input longint unsigned radicand);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 24; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= radicand) root = trial;
    end
    return root;
  endfunction

  function automatic logic [LumW-1:0] vignette_lum(input logic [CoordW-1:0] col,
                                                   input logic [CoordW-1:0] row,
                                                   input logic [LumW-1:0] lum,
                                                   input logic signed [CfgW-1:0] ccol,
                                                   input logic signed [CfgW-1:0] crow,
                                                   output bit saturated);
    longint          dx;
    longint          dy;
    longint unsigned dist_q8;
    longint unsigned factor;
    longint unsigned prod;
    dx = longint'({1'b0, col}) - longint'(ccol);
    dy = longint'({1'b0, row}) - longint'(crow);
    dist_q8 = floor_sqrt(longint'(dx * dx + dy * dy) << 16);
    saturated = (dist_q8 >= SatDistQ8);
    // 0.005 per pixel is 1.28 per Q.8 step of the distance
    factor = saturated ? FloorQ16 : OneQ16 - (dist_q8 * 128) / 100;
    prod = longint'(lum) * factor;
    return prod[LumW+15:16];
  endfunction

  // result checker and predictor, all on sampled values
  always @(posedge clk_i) begin
    lum_expect_t ent;
    bit          sat;
    if (rst_ni) begin
      if (done_o) begin
        results_seen++;
        if (lum_expect_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MaxReports)
            $display("%0t: unexpected result lum_out=%h", $realtime, lum_out_o);
        end else begin
          ent = lum_expect_q.pop_front();
          if (lum_out_o !== ent.lum_exp) begin
            fail_cnt++;
            if (fail_cnt <= MaxReports)
              $display("%0t: lum_out mismatch for col=%0d row=%0d lum=%h: expected %h got %h",
                       $realtime, ent.col, ent.row, ent.lum, ent.lum_exp, lum_out_o);
          end
        end
      end
      if (start_i && !busy_o) begin
        ent.col = pixel_col_i;
        ent.row = pixel_row_i;
        ent.lum = lum_in_i;
        ent.lum_exp = vignette_lum(pixel_col_i, pixel_row_i, lum_in_i, spot_col, spot_row,
                                   sat);
        if (drv_typed) ent.lum_exp = drv_typed_lum;
        if (sat) saturated_cnt++;
        else in_radius_cnt++;
        lum_expect_q.push_back(ent);
        pixels_sent++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgCenterCol: spot_col = cfg_data_i;
          CfgCenterRow: spot_row = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  task automatic send_pixel(input logic [CoordW-1:0] col, input logic [CoordW-1:0] row,
                            input logic [LumW-1:0] lum, input logic typed,
                            input logic [LumW-1:0] typed_lum, input int idle_pct);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start_i     <= 1'b0;
      pixel_col_i <= CoordW'($urandom);
      pixel_row_i <= CoordW'($urandom);
      lum_in_i    <= LumW'($urandom);
      @(negedge clk_i);
    end
    start_i       <= 1'b1;
    pixel_col_i   <= col;
    pixel_row_i   <= row;
    lum_in_i      <= lum;
    drv_typed     <= typed;
    drv_typed_lum <= typed_lum;
    do @(posedge clk_i); while (busy_o);
  endtask

  // stop sending and let every pending result come out
  task automatic drain_pipe();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (lum_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_center(input int ccol, input int crow);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgCenterCol;
    cfg_data_i <= CfgW'(ccol);
    @(negedge clk_i);
    cfg_idx_i  <= CfgCenterRow;
    cfg_data_i <= CfgW'(crow);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    drv_ccol = ccol;
    drv_crow = crow;
    center_writes++;
  endtask

  function automatic logic [CoordW-1:0] near_coord(input int center);
    int c;
    // straddle the 160 pixel radius, clipped to the image
    c = center + int'($urandom_range(340)) - 170;
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    return CoordW'(c);
  endfunction

  initial begin
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [LumW-1:0]   lum;
    int                idle;
    int                pc;
    int                pr;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    pixel_col_i   = '0;
    pixel_row_i   = '0;
    lum_in_i      = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgCenterCol;
    cfg_data_i    = '0;
    drv_typed     = 1'b0;
    drv_typed_lum = '0;
    spot_col      = '0;
    spot_row      = '0;
    drv_ccol      = 0;
    drv_crow      = 0;
    fail_cnt      = 0;
    pixels_sent   = 0;
    results_seen  = 0;
    in_radius_cnt = 0;
    saturated_cnt = 0;
    center_writes = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DirRows; i++) begin
      if (int'(DirTbl[i].ccol) != drv_ccol || int'(DirTbl[i].crow) != drv_crow) begin
        drain_pipe();
        set_center(DirTbl[i].ccol, DirTbl[i].crow);
      end
      send_pixel(DirTbl[i].col, DirTbl[i].row, DirTbl[i].lum, DirTbl[i].typed,
                 DirTbl[i].lum_exp, 0);
    end

    for (int p = 0; p < NumPhases; p++) begin
      pc = PhaseCol[p];
      pr = PhaseRow[p];
      if (p == NumPhases - 1) begin
        pc = int'($urandom_range(4300)) - 200;
        pr = int'($urandom_range(4300)) - 200;
      end
      drain_pipe();
      set_center(pc, pr);
      for (int n = 0; n < PhaseLen[p]; n++) begin
        if (p == 3 && n == PhaseLen[p] / 2) drain_pipe();
        if ($urandom_range(99) < 70) begin
          col = near_coord(pc);
          row = near_coord(pr);
        end else begin
          col = CoordW'($urandom);
          row = CoordW'($urandom);
        end
        case ($urandom_range(9))
          0: lum = '0;
          1: lum = '1;
          default: lum = LumW'($urandom);
        endcase
        // bursts with no gaps inside the idling phases
        idle = ((n % 48) < 16) ? 0 : PhaseIdle[p];
        send_pixel(col, row, lum, 1'b0, '0, idle);
      end
    end

    drain_pipe();
    repeat (SettleCyc) @(posedge clk_i);
    if (lum_expect_q.size() != 0) fail_cnt++;

    $display("%0d pixels over %0d center settings, %0d inside the falloff radius",
             pixels_sent, center_writes + 1, in_radius_cnt);
    $display("%0d saturated at the 0.2 floor, %0d results checked, %0d failures",
             saturated_cnt, results_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d results outstanding", lum_expect_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
